// ===== rtl/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the route lookup
// Field widths, table sizing, status and item kind codes, beat and command
// structs, and the prefix mask helper.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 6;
  localparam int PORT_W     = 4;
  localparam int TTL_W      = 8;
  localparam int STATUS_W   = 3;

  localparam int MAX_ROUTES = 64;
  localparam int PORT_COUNT = 16;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOROUTE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TTLEXP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_ROUTE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] pfx_addr;
    logic [LEN_W-1:0]  pfx_len;
    logic              has_next_hop;
    logic [ADDR_W-1:0] hop_address;
    logic [PORT_W-1:0] port_index;
    logic [ADDR_W-1:0] dst_addr;
    logic [TTL_W-1:0]  ttl_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   out_port;
    logic [ADDR_W-1:0]   out_next_hop;
    logic [TTL_W-1:0]    ttl_out;
  } out_item_t;

  // One stored route, with its match mask worked out at add time.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [LEN_W-1:0]  length;
    logic              hop_valid;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic              is_route;
    route_entry_t      entry;
    logic [ADDR_W-1:0] dst;
    logic [TTL_W-1:0]  ttl;
  } cmd_t;

  // Queue occupancy as seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // Mask of the leading len bits; len is already clamped to ADDR_W.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/lpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_front: input side of the route lookup
// Takes input beats while the command queue has room, clamps the prefix
// length, reduces the port, builds the match mask and pushes one command.
// ----------------------------------------------------------------------------
module lpr_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  lpr_pkg::in_item_t in_data,
  input  lpr_pkg::q_status_t q_status,
  output logic              q_push,
  output lpr_pkg::cmd_t     q_cmd
);
  import lpr_pkg::*;

  logic [LEN_W-1:0] len_clamped;

  assign in_ready = ~q_status.full;
  assign q_push   = in_valid & in_ready;

  always_comb begin
    if (in_data.pfx_len > LEN_W'(ADDR_W)) begin
      len_clamped = LEN_W'(ADDR_W);
    end else begin
      len_clamped = in_data.pfx_len;
    end
  end

  always_comb begin
    q_cmd.is_route        = (in_data.kind == KIND_ROUTE);
    q_cmd.entry.prefix    = in_data.pfx_addr;
    q_cmd.entry.mask      = prefix_mask(len_clamped);
    q_cmd.entry.length    = len_clamped;
    q_cmd.entry.hop_valid = in_data.has_next_hop;
    q_cmd.entry.hop       = in_data.hop_address;
    q_cmd.entry.port      = PORT_W'(int'(in_data.port_index) % PORT_COUNT);
    q_cmd.dst             = in_data.dst_addr;
    q_cmd.ttl             = in_data.ttl_in;
  end

endmodule

// ===== rtl/lpr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_queue: command queue between front and lookup engine
// A small in-order queue of classified commands, so that input and result
// sides stall independently.
// ----------------------------------------------------------------------------
module lpr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpr_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output lpr_pkg::cmd_t      pop_cmd,
  output lpr_pkg::q_status_t status
);
  import lpr_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.valid = (count_r != '0);
  assign pop_cmd      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/lpr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_engine: route table and lookup engine
// Stores added routes in a single-port-write table memory and scans it one
// entry per cycle for the longest matching prefix; holds the result beat.
// ----------------------------------------------------------------------------
module lpr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lpr_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lpr_pkg::out_item_t out_data
);
  import lpr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  route_entry_t      mem [MAX_ROUTES];
  route_entry_t      rd_data_r;
  logic              mem_we;
  logic              mem_re;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              pending_r, pending_nxt;
  logic              found_r, found_nxt;
  logic [LEN_W-1:0]  best_len_r, best_len_nxt;
  logic [PORT_W-1:0] best_port_r, best_port_nxt;
  logic [ADDR_W-1:0] best_hop_r, best_hop_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [TTL_W-1:0]  ttl_r, ttl_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              out_free;
  logic              table_full;
  logic              scan_more;
  logic              hit;
  logic              better;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = ~out_valid_r | out_ready;
  assign table_full = (count_r == CNT_W'(MAX_ROUTES));
  assign scan_more  = (issue_r != count_r);

  // Adds finish in the cycle they leave the queue, so they need the result slot.
  assign q_pop  = q_valid && (state_r == S_IDLE) && (q_cmd.is_route || out_free);
  assign mem_we = q_pop && !q_cmd.is_route && !table_full;
  assign mem_re = (state_r == S_SCAN) && scan_more;

  assign hit    = ((rd_data_r.prefix ^ dst_r) & rd_data_r.mask) == '0;
  assign better = hit && (!found_r || (rd_data_r.length > best_len_r));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    pending_nxt   = pending_r;
    found_nxt     = found_r;
    best_len_nxt  = best_len_r;
    best_port_nxt = best_port_r;
    best_hop_nxt  = best_hop_r;
    dst_nxt       = dst_r;
    ttl_nxt       = ttl_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_cmd.is_route) begin
            dst_nxt     = q_cmd.dst;
            ttl_nxt     = q_cmd.ttl;
            found_nxt   = 1'b0;
            issue_nxt   = '0;
            pending_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (table_full) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              out_data_nxt.status = ST_ADDED;
              count_nxt           = count_r + CNT_W'(1);
            end
          end
        end
      end
      S_SCAN: begin
        pending_nxt = scan_more;
        if (scan_more) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (pending_r && better) begin
          found_nxt     = 1'b1;
          best_len_nxt  = rd_data_r.length;
          best_port_nxt = rd_data_r.port;
          best_hop_nxt  = rd_data_r.hop_valid ? rd_data_r.hop : dst_r;
        end
        if (!scan_more && !pending_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (!found_r) begin
            out_data_nxt.status = ST_NOROUTE;
          end else if (ttl_r <= TTL_W'(1)) begin
            out_data_nxt.status = ST_TTLEXP;
          end else begin
            out_data_nxt.status       = ST_FORWARD;
            out_data_nxt.out_port     = best_port_r;
            out_data_nxt.out_next_hop = best_hop_r;
            out_data_nxt.ttl_out      = ttl_r - TTL_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      pending_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pending_r   <= pending_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_len_r  <= best_len_nxt;
    best_port_r <= best_port_nxt;
    best_hop_r  <= best_hop_nxt;
    dst_r       <= dst_nxt;
    ttl_r       <= ttl_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Route table: one write port at the fill count, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= q_cmd.entry;
    end
    if (mem_re) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

endmodule

// ===== rtl/longest_prefix_route_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup: IPv4 longest prefix match routing table
// Front classifier, command queue and table lookup engine with a held
// result beat.
// ----------------------------------------------------------------------------
// An add beat appends a route to a table of MAX_ROUTES entries; it answers
// "route added", or "table full" once all entries are used. A route beat
// scans every stored route through the table memory's single read port,
// one entry per cycle. The longest matching prefix wins, the earliest added
// among equal lengths, and a zero length matches any address. A datagram
// with a match and a TTL above one is forwarded with the TTL lowered by one
// and the route's next hop, or its own destination for a directly connected
// route; otherwise the result beat reports no route or TTL expired. A
// two-entry queue sits between the input side and the engine, so input
// beats are taken while a lookup runs or a result beat waits for the
// consumer. Results come back in input order, exactly one per input beat.
// The table needs no clearing after reset: only entries below the fill
// count are ever read.
module longest_prefix_route_lookup (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpr_pkg::out_item_t out_data
);
  import lpr_pkg::*;

  logic      q_push;
  cmd_t      q_in_cmd;
  logic      q_pop;
  cmd_t      q_out_cmd;
  q_status_t q_status;

  lpr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd)
  );

  lpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .status   (q_status)
  );

  lpr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_status.valid),
    .q_cmd     (q_out_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The engine only pops a command that is really queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_status.valid)
    else $error("engine popped an empty command queue");

  // An add command leaves its result beat in the output register next cycle.
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_out_cmd.is_route) |=> out_valid)
    else $error("add command produced no result beat");

  // A pop always leaves room for the next input beat.
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> in_ready)
    else $error("queue still full after a pop");

  // Reset leaves no result beat pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

endmodule
